// ===== rtl/core/mhta_pkg.sv =====
// mhta_pkg: shared types and constants for the min-heap track allocator
// no dependencies; used by the allocator top level and its port checker

package mhta_pkg;

	// field widths of one input item and one result item
	localparam int TIME_W      = 32;
	localparam int TN_W        = 9;
	localparam int IN_TDATA_W  = 64;
	localparam int OUT_TDATA_W = 16;

	// result bit positions inside the output tdata
	localparam int OUT_REUSED_BIT = TN_W;
	localparam int OUT_FULL_BIT   = TN_W + 1;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROOT,
		ST_LAST,
		ST_DN_CMP,
		ST_UP_RD,
		ST_UP_CMP,
		ST_UP_TOP,
		ST_DONE
	} mhta_state_t;

endpackage

// ===== rtl/core/min_heap_track_allocator_unit.sv =====
// min_heap_track_allocator_unit: track allocator built on a min-heap of departure times
// depends on mhta_pkg; the heap lives in a dual-read, single-write synchronous memory
//
//  channel   | dir | fields (lsb first)
//  ----------+-----+--------------------------------------------------------
//  s_axis    | in  | arrival_time[31:0], departure_time[63:32]
//  m_axis    | out | tracks_needed[8:0], reused_track[9], full_error[10]
//
// one item at a time: a root lookup, then on a reuse a read of the last entry and a
// sift-down, then a sift-up unless the heap is full; each walk covers at most
// log2(HEAP_DEPTH) levels, and at each level the children or parent come from the
// registered memory read ports.
// arst_n clears the sequencer, the entry count and the output valid; heap contents stay.
// a stalled result holds in the output register; the next item is taken meanwhile
// and waits in the done state until that register frees.

module min_heap_track_allocator_unit
	import mhta_pkg::*;
#(
	parameter int HEAP_DEPTH = 256
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// tdata: arrival_time[31:0], departure_time[63:32]
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// tdata: tracks_needed[8:0], reused_track[9], full_error[10], zero fill
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready
);

	localparam int AW  = $clog2(HEAP_DEPTH);
	localparam int CW  = $clog2(HEAP_DEPTH + 1);
	localparam int CHW = AW + 2;

	// heap storage and its registered read ports
	logic [TIME_W-1:0] heap_mem [HEAP_DEPTH];
	logic [TIME_W-1:0] rd_a_q, rd_b_q;
	logic              rd_en, wr_en;
	logic [AW-1:0]     rd_a_addr, rd_b_addr, wr_addr;
	logic [TIME_W-1:0] wr_data;

	mhta_state_t state_q, state_d;

	logic [TIME_W-1:0] arr_q, dep_q, val_q;
	logic [AW-1:0]     pos_q;
	logic [CW-1:0]     count_q;
	logic              l_ok_q, r_ok_q;
	logic              reused_q, full_q;
	logic              out_valid_q;
	logic [TN_W-1:0]   out_count_q;
	logic              out_reused_q, out_full_q;

	logic              in_xfer;
	logic              root_hit;
	logic              at_capacity;
	logic [CHW-1:0]    l_idx, r_idx;
	logic              go_l, go_r, dn_move;
	logic [TIME_W-1:0] l_best_val, best_val;
	logic [AW-1:0]     best_idx;
	logic [CHW-1:0]    best_l, best_r;
	logic              best_l_ok, best_r_ok;
	logic [AW-1:0]     up_par, up_gpar, ins_par;
	logic              up_move;
	logic              out_load;

	assign in_xfer     = s_axis_tvalid && s_axis_tready;
	assign root_hit    = (count_q != '0) && (rd_a_q < arr_q);
	assign at_capacity = (count_q >= CW'(HEAP_DEPTH));

	// sift-down compare: pick the smaller child, ties stay put
	assign l_idx      = {1'b0, pos_q, 1'b1};
	assign r_idx      = l_idx + CHW'(1);
	assign go_l       = l_ok_q && (val_q > rd_a_q);
	assign l_best_val = go_l ? rd_a_q : val_q;
	assign go_r       = r_ok_q && (l_best_val > rd_b_q);
	assign dn_move    = go_l || go_r;
	assign best_val   = go_r ? rd_b_q : rd_a_q;
	assign best_idx   = go_r ? r_idx[AW-1:0] : l_idx[AW-1:0];
	assign best_l     = {1'b0, best_idx, 1'b1};
	assign best_r     = best_l + CHW'(1);
	assign best_l_ok  = best_l < CHW'(count_q);
	assign best_r_ok  = best_r < CHW'(count_q);

	// sift-up parents
	assign ins_par = AW'((count_q - CW'(1)) >> 1);
	assign up_par  = (pos_q - AW'(1)) >> 1;
	assign up_gpar = (up_par - AW'(1)) >> 1;
	assign up_move = dep_q < rd_a_q;

	assign out_load = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready);

	// memory: one write port, two read ports with registered data
	always_ff @(posedge clk) begin
		if (wr_en) begin
			heap_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_a_q <= heap_mem[rd_a_addr];
			rd_b_q <= heap_mem[rd_b_addr];
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and memory controls
	always_comb begin
		state_d   = state_q;
		rd_en     = 1'b0;
		rd_a_addr = '0;
		rd_b_addr = '0;
		wr_en     = 1'b0;
		wr_addr   = pos_q;
		wr_data   = val_q;
		case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					rd_en   = 1'b1;
					state_d = ST_ROOT;
				end
			end
			ST_ROOT: begin
				if (root_hit) begin
					rd_en     = 1'b1;
					rd_a_addr = AW'(count_q - CW'(1));
					state_d   = ST_LAST;
				end else begin
					state_d = ST_UP_RD;
				end
			end
			ST_LAST: begin
				if (count_q == '0) begin
					state_d = ST_UP_RD;
				end else begin
					rd_en     = 1'b1;
					rd_a_addr = AW'(CHW'(1));
					rd_b_addr = AW'(CHW'(2));
					state_d   = ST_DN_CMP;
				end
			end
			ST_DN_CMP: begin
				wr_en = 1'b1;
				if (dn_move) begin
					wr_data   = best_val;
					rd_en     = 1'b1;
					rd_a_addr = best_l[AW-1:0];
					rd_b_addr = best_r[AW-1:0];
				end else begin
					state_d = ST_UP_RD;
				end
			end
			ST_UP_RD: begin
				if (at_capacity) begin
					state_d = ST_DONE;
				end else if (count_q == '0) begin
					wr_en   = 1'b1;
					wr_addr = '0;
					wr_data = dep_q;
					state_d = ST_DONE;
				end else begin
					rd_en     = 1'b1;
					rd_a_addr = ins_par;
					state_d   = ST_UP_CMP;
				end
			end
			ST_UP_CMP: begin
				wr_en = 1'b1;
				if (up_move) begin
					wr_data = rd_a_q;
					if (up_par == '0) begin
						state_d = ST_UP_TOP;
					end else begin
						rd_en     = 1'b1;
						rd_a_addr = up_gpar;
					end
				end else begin
					wr_data = dep_q;
					state_d = ST_DONE;
				end
			end
			ST_UP_TOP: begin
				wr_en   = 1'b1;
				wr_addr = '0;
				wr_data = dep_q;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (state_q == ST_ROOT && root_hit) begin
			count_q <= count_q - CW'(1);
		end else if (state_q == ST_UP_RD && !at_capacity) begin
			count_q <= count_q + CW'(1);
		end
	end

	// item registers and walk position
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					arr_q <= s_axis_tdata[TIME_W-1:0];
					dep_q <= s_axis_tdata[2*TIME_W-1:TIME_W];
				end
			end
			ST_ROOT: begin
				reused_q <= root_hit;
			end
			ST_LAST: begin
				val_q  <= rd_a_q;
				pos_q  <= '0;
				l_ok_q <= CHW'(1) < CHW'(count_q);
				r_ok_q <= CHW'(2) < CHW'(count_q);
			end
			ST_DN_CMP: begin
				if (dn_move) begin
					pos_q  <= best_idx;
					l_ok_q <= best_l_ok;
					r_ok_q <= best_r_ok;
				end
			end
			ST_UP_RD: begin
				full_q <= at_capacity;
				pos_q  <= count_q[AW-1:0];
			end
			ST_UP_CMP: begin
				if (up_move) begin
					pos_q <= up_par;
				end
			end
			default: begin
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_count_q  <= TN_W'(count_q);
			out_reused_q <= reused_q;
			out_full_q   <= full_q;
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(OUT_TDATA_W - TN_W - 2){1'b0}}, out_full_q, out_reused_q,
		out_count_q};

endmodule

// ===== rtl/core/mhta_checker.sv =====
// mhta_checker: port-level checks for the min-heap track allocator
// depends on mhta_pkg; bound to min_heap_track_allocator_unit below

module mhta_checker
	import mhta_pkg::*;
#(
	parameter int HEAP_DEPTH = 256
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_axis_tvalid,
	input logic                   s_axis_tready,
	input logic [OUT_TDATA_W-1:0] m_axis_tdata,
	input logic                   m_axis_tvalid,
	input logic                   m_axis_tready
);

	// a stalled result keeps its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// an accepted item keeps the input closed on the next cycle
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input reopened right after a transfer");

	// a reused track never comes with a full heap
	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(m_axis_tdata[OUT_REUSED_BIT] && m_axis_tdata[OUT_FULL_BIT]))
		else $error("reuse and full flagged together");

	// a full heap reports the full depth
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[OUT_FULL_BIT] |->
			m_axis_tdata[TN_W-1:0] == TN_W'(HEAP_DEPTH))
		else $error("full flag with a count below the depth");

endmodule

bind min_heap_track_allocator_unit mhta_checker #(.HEAP_DEPTH(HEAP_DEPTH)) u_mhta_checker (.*);

// ===== tb/tb_min_heap_track_allocator_unit.sv =====
// tb_min_heap_track_allocator_unit: self-checking regression for the min-heap track allocator
// depends on mhta_pkg and min_heap_track_allocator_unit; predicts every result with its own heap
// and runs directed trains, ramped random traffic and a heap-full burst under varied flow control

`timescale 1ns / 1ps

module tb_min_heap_track_allocator_unit;
	import mhta_pkg::*;

	localparam int          DEPTH        = 256;
	localparam int          RANDOM_ITEMS = 1700;
	localparam int          PHASE_ITEMS  = RANDOM_ITEMS / 4;
	localparam int          DRAIN_CYCLES = 64;
	localparam int unsigned CYCLE_LIMIT  = 1500000;

	typedef logic [TIME_W-1:0] time_word_t;

	// one expected result transfer
	typedef struct packed {
		logic            full_error;
		logic            reused_track;
		logic [TN_W-1:0] tracks_needed;
	} track_result_t;

	// keeps a private departure heap and matches results in order
	class track_count_scoreboard;
		time_word_t      departures [DEPTH];
		int unsigned     live_tracks;
		track_result_t   expected_results [$];
		int unsigned     mismatches;
		int unsigned     checked;
		int unsigned     reuse_seen;
		int unsigned     full_seen;

		function new();
			live_tracks = 0;
			mismatches  = 0;
			checked     = 0;
			reuse_seen  = 0;
			full_seen   = 0;
		endfunction

		function void swap_slots(input int unsigned a, input int unsigned b);
			time_word_t held;
			held          = departures[a];
			departures[a] = departures[b];
			departures[b] = held;
		endfunction

		// work out the result of one accepted train
		function void note_train(input time_word_t arrive, input time_word_t depart);
			track_result_t res;
			int unsigned   pos;
			int unsigned   best;
			int unsigned   kid;
			bit            settled;
			res = '0;
			// free the earliest departing track if it left strictly before this arrival
			if (live_tracks != 0 && departures[0] < arrive) begin
				res.reused_track = 1'b1;
				departures[0]    = departures[live_tracks - 1];
				live_tracks--;
				pos     = 0;
				settled = 0;
				while (!settled) begin
					best = pos;
					kid  = 2 * pos + 1;
					if (kid < live_tracks && departures[kid] < departures[best])
						best = kid;
					if (kid + 1 < live_tracks && departures[kid + 1] < departures[best])
						best = kid + 1;
					if (best == pos) begin
						settled = 1;
					end else begin
						swap_slots(pos, best);
						pos = best;
					end
				end
			end
			// push the departure, or flag a full heap
			if (live_tracks < DEPTH) begin
				pos             = live_tracks;
				departures[pos] = depart;
				while (pos > 0 && departures[pos] < departures[(pos - 1) / 2]) begin
					swap_slots(pos, (pos - 1) / 2);
					pos = (pos - 1) / 2;
				end
				live_tracks++;
			end else begin
				res.full_error = 1'b1;
			end
			res.tracks_needed = live_tracks[TN_W-1:0];
			expected_results.push_back(res);
		endfunction

		// compare one result transfer with the oldest expectation
		function void check_tracks(input logic [OUT_TDATA_W-1:0] data);
			track_result_t want;
			logic [TN_W-1:0] got_tracks;
			logic            got_reused;
			logic            got_full;
			got_tracks = data[TN_W-1:0];
			got_reused = data[OUT_REUSED_BIT];
			got_full   = data[OUT_FULL_BIT];
			if (expected_results.size() == 0) begin
				$error("result transfer with nothing expected: tdata %h", data);
				mismatches++;
			end else begin
				want = expected_results.pop_front();
				checked++;
				if (got_tracks !== want.tracks_needed) begin
					$error("tracks_needed: expected %0d, got %0d", want.tracks_needed,
						got_tracks);
					mismatches++;
				end
				if (got_reused !== want.reused_track) begin
					$error("reused_track: expected %0d, got %0d", want.reused_track,
						got_reused);
					mismatches++;
				end
				if (got_full !== want.full_error) begin
					$error("full_error: expected %0d, got %0d", want.full_error, got_full);
					mismatches++;
				end
				if (want.reused_track)
					reuse_seen++;
				if (want.full_error)
					full_seen++;
			end
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic [IN_TDATA_W-1:0]  s_axis_tdata;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;

	int unsigned            send_idle_pct;
	int unsigned            recv_stall_pct;
	int unsigned            cycle_count;
	time_word_t             clock_now;
	track_count_scoreboard  board;

	min_heap_track_allocator_unit #(
		.HEAP_DEPTH(DEPTH)
	) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// receiver back-pressure, changed on the falling edge
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			board.check_tracks(m_axis_tdata);
	end

	// watchdog
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("watchdog expired after %0d cycles, %0d results outstanding", cycle_count,
			board.expected_results.size());
		$display("min_heap_track_allocator_unit regression: fail");
		$finish;
	end

	// one train transfer; called and returns at a falling edge
	task automatic send_train(input time_word_t arrive, input time_word_t depart);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			do @(negedge clk); while ($urandom_range(0, 99) < send_idle_pct);
		end
		s_axis_tdata  <= {depart, arrive};
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		board.note_train(arrive, depart);
		@(negedge clk);
	endtask

	// field extremes, equal times and reuse from a fresh heap
	task automatic run_directed();
		time_word_t arrivals [16];
		time_word_t leaves [16];
		arrivals = '{32'h0, 32'h0, 32'h1, 32'h1, 32'h1, 32'hA,
			32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'h8000_0000, 32'h8000_0000, 32'hAAAA_AAAA, 32'h5555_5555,
			32'h0, 32'hFFFF_FFFF};
		leaves = '{32'h0, 32'h0, 32'hA, 32'h1, 32'h7, 32'h14,
			32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'h7FFF_FFFF, 32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA,
			32'hFFFF_FFFE, 32'h0};
		foreach (arrivals[i])
			send_train(arrivals[i], leaves[i]);
	endtask

	// mostly in-order trains with a widening stay, plus noise and late arrivals
	task automatic run_random_phase(input int unsigned first_index);
		int unsigned roll;
		int unsigned span;
		time_word_t  arrive;
		time_word_t  depart;
		for (int unsigned k = first_index; k < first_index + PHASE_ITEMS; k++) begin
			roll = $urandom_range(0, 99);
			span = 8 + (k * 500) / RANDOM_ITEMS;
			if (roll < 4) begin
				arrive = $urandom;
				depart = $urandom;
			end else if (roll < 8) begin
				arrive = clock_now - $urandom_range(0, 40);
				depart = arrive - $urandom_range(0, 3);
			end else begin
				clock_now = clock_now + $urandom_range(0, 4);
				arrive    = clock_now;
				depart    = clock_now + $urandom_range(0, span);
			end
			send_train(arrive, depart);
		end
	endtask

	// fill the heap, then drive it into the full case and reuse at full depth
	task automatic run_fill();
		while (board.live_tracks < DEPTH)
			send_train(32'h0, $urandom);
		repeat (12)
			send_train(32'h0, $urandom);
		repeat (6)
			send_train(32'hFFFF_FFFF, $urandom);
		send_train(32'h0, 32'hFFFF_FFFF);
	endtask

	// stimulus and verdict
	initial begin
		board          = new();
		arst_n         = 1'b0;
		s_axis_tdata   = '0;
		s_axis_tvalid  = 1'b0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		clock_now      = '0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		run_directed();
		run_random_phase(0);
		send_idle_pct = 63;
		run_random_phase(PHASE_ITEMS);
		send_idle_pct  = 0;
		recv_stall_pct = 63;
		run_random_phase(2 * PHASE_ITEMS);
		send_idle_pct  = 20;
		recv_stall_pct = 20;
		run_random_phase(3 * PHASE_ITEMS);
		run_fill();
		s_axis_tvalid <= 1'b0;

		// let every expected result arrive, then watch for strays
		while (board.expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.expected_results.size() != 0) begin
			$error("%0d expected results never arrived", board.expected_results.size());
			board.mismatches++;
		end

		$display("checked %0d results: %0d with a reused track, %0d heap-full drops,",
			board.checked, board.reuse_seen, board.full_seen);
		$display("heap grown to %0d of %0d tracks across four flow-control phases",
			board.live_tracks, DEPTH);
		if (board.mismatches == 0) begin
			$display("min_heap_track_allocator_unit regression: pass");
		end else begin
			$display("min_heap_track_allocator_unit regression: fail");
		end
		$finish;
	end

endmodule
